[hdl/hcbd_pkg.sv]
`timescale 1ns / 1ps

package hcbd_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_SIZE_LINE_CHARS = 9;
  localparam int unsigned DEF_LENGTH_BITS     = 31;

  // Fixed field widths of the channels.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 2;

  // Entries in the queue between the classifier and the decoder.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Character codes the decoder looks for.
  localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_SEMI = 8'h3B;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_PAYLOAD = 3'd1,
    PH_SKIP    = 3'd2,
    PH_TRAILER = 3'd3,
    PH_ERROR   = 3'd4
  } phase_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EOM     = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  // Carriage return seen on the size line, waiting for its line feed.
  typedef enum logic [1:0] {
    PCR_NONE      = 2'd0,
    PCR_UNCOUNTED = 2'd1,
    PCR_COUNTED   = 2'd2
  } pcr_e;

  // One byte after classification.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              is_cr;
    logic              is_lf;
    logic              is_semi;
    logic              is_hex;
    logic [3:0]        hex_val;
  } cls_t;

endpackage

[hdl/hcbd_if.sv]
`timescale 1ns / 1ps

interface hcbd_in_if;
  import hcbd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface hcbd_out_if;
  import hcbd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [KIND_W-1:0] kind;
  logic              chunk_last;

  modport source (output valid, output out_byte, output kind, output chunk_last, input ready);
  modport sink (input valid, input out_byte, input kind, input chunk_last, output ready);
endinterface

[hdl/http_chunked_body_decoder_top.sv]
`timescale 1ns / 1ps

// Chunked body decoder: takes an HTTP chunked body one byte per transfer and
// returns payload bytes (kind 0, chunk_last on the final byte of each chunk),
// an end-of-message mark (kind 1) after the trailer's closing CR LF CR LF, or
// a sticky format error (kind 2) that only reset clears. Size lines, the two
// bytes after each chunk and trailer bytes give no result. The block sustains
// one byte per clock while the output is not stalled; that rate is set by the
// decoder's state update, which turns one queued byte into its result each
// cycle. A byte accepted from the input is classified and written into a
// two-entry queue, then decoded from the queue's head into the output
// register, from which its result is offered. The queue and the output
// register let input and output stall independently.
module http_chunked_body_decoder_top #(
  parameter int unsigned SIZE_LINE_CHARS = hcbd_pkg::DEF_SIZE_LINE_CHARS,
  parameter int unsigned LENGTH_BITS     = hcbd_pkg::DEF_LENGTH_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hcbd_in_if.sink    in_chan_i,
  hcbd_out_if.source out_chan_o
);
  import hcbd_pkg::*;

  // Classified byte from the front end into the queue.
  cls_t fe_entry;
  logic fe_push;
  logic q_full;

  // Head of the queue toward the decoder.
  cls_t q_head;
  logic q_valid;
  logic be_pop;

  // The front end flags CR, LF, ';' and hex digits and pushes the byte into
  // the queue whenever the queue has room.
  hcbd_front u_front (
    .in_chan_i (in_chan_i),
    .full_i    (q_full),
    .push_o    (fe_push),
    .entry_o   (fe_entry)
  );

  hcbd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .entry_i (fe_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head),
    .pop_i   (be_pop)
  );

  // The back end holds the size line, chunk and trailer state and owns the
  // output register; it pops a byte whenever that register can take its
  // result, including a byte that gives no result.
  hcbd_back #(
    .SizeLineChars (SIZE_LINE_CHARS),
    .LengthBits    (LENGTH_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (q_valid),
    .entry_i       (q_head),
    .pop_o         (be_pop),
    .out_chan_o    (out_chan_o)
  );

endmodule

[hdl/hcbd_front.sv]
`timescale 1ns / 1ps

module hcbd_front (
  hcbd_in_if.sink       in_chan_i,
  input  logic          full_i,
  output logic          push_o,
  output hcbd_pkg::cls_t entry_o
);
  import hcbd_pkg::*;

  logic [BYTE_W-1:0] c;

  assign c               = in_chan_i.data_byte;
  assign in_chan_i.ready = !full_i;
  assign push_o          = in_chan_i.valid && !full_i;

  // Decode the byte once here so the decoder loop only sees flags.
  always_comb begin
    entry_o         = '0;
    entry_o.data    = c;
    entry_o.is_cr   = (c == CHAR_CR);
    entry_o.is_lf   = (c == CHAR_LF);
    entry_o.is_semi = (c == CHAR_SEMI);
    if (c >= 8'h30 && c <= 8'h39) begin
      entry_o.is_hex  = 1'b1;
      entry_o.hex_val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      entry_o.is_hex  = 1'b1;
      entry_o.hex_val = c[3:0] + 4'd9;
    end
  end

endmodule

[hdl/hcbd_queue.sv]
`timescale 1ns / 1ps

module hcbd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hcbd_pkg::cls_t entry_i,
  output logic           full_o,
  output logic           valid_o,
  output hcbd_pkg::cls_t head_o,
  input  logic           pop_i
);
  import hcbd_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cls_t            store_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= entry_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(QUEUE_DEPTH))
    else $error("queue count above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");

endmodule

[hdl/hcbd_back.sv]
`timescale 1ns / 1ps

module hcbd_back #(
  parameter int unsigned SizeLineChars = hcbd_pkg::DEF_SIZE_LINE_CHARS,
  parameter int unsigned LengthBits    = hcbd_pkg::DEF_LENGTH_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           entry_valid_i,
  input  hcbd_pkg::cls_t entry_i,
  output logic           pop_o,
  hcbd_out_if.source     out_chan_o
);
  import hcbd_pkg::*;

  localparam int unsigned PosW = $clog2(SizeLineChars + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(SizeLineChars);

  phase_e                phase_q, phase_d;
  logic [LengthBits-1:0] rem_q, rem_d;
  logic [LengthBits-1:0] acc_q, acc_d;
  logic [PosW-1:0]       pos_q, pos_d;
  logic                  ext_q, ext_d;
  pcr_e                  pend_q, pend_d;
  logic [1:0]            match_q, match_d;

  logic                  out_valid_q;
  logic [BYTE_W-1:0]     out_byte_q;
  kind_e                 out_kind_q;
  logic                  out_last_q;

  logic                  counted, first, lf_ends, cr_bad, acc_ovf, size_err;
  logic                  trl_hit, eom, pay_last;

  logic                  res_valid;
  kind_e                 res_kind;
  logic [BYTE_W-1:0]     res_byte;
  logic                  res_last;

  assign pop_o = entry_valid_i && (!out_valid_q || out_chan_o.ready);

  // Decode of the current byte against the line and trailer state.
  always_comb begin
    counted  = (pos_q < PosMax) && !ext_q;
    first    = (pos_q == '0);
    lf_ends  = (pend_q != PCR_NONE) && entry_i.is_lf;
    cr_bad   = (pend_q == PCR_COUNTED) && !entry_i.is_lf;
    acc_ovf  = (acc_q[LengthBits-1 -: 4] != '0);
    size_err = cr_bad ||
               (!lf_ends &&
                ((entry_i.is_cr && first) ||
                 (!entry_i.is_cr && counted && !(entry_i.is_semi && !first) &&
                  (!entry_i.is_hex || acc_ovf))));
    trl_hit  = match_q[0] ? entry_i.is_lf : entry_i.is_cr;
    eom      = trl_hit && (match_q == 2'd3);
    pay_last = (rem_q[LengthBits-1:1] == '0);
  end

  // Next state.
  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    acc_d   = acc_q;
    pos_d   = pos_q;
    ext_d   = ext_q;
    pend_d  = pend_q;
    match_d = match_q;
    if (pop_o) begin
      unique case (phase_q)
        PH_PAYLOAD: begin
          rem_d = rem_q - 1'b1;
          if (pay_last) begin
            phase_d = PH_SKIP;
            rem_d   = LengthBits'(2);
          end
        end
        PH_SKIP: begin
          rem_d = rem_q - 1'b1;
          if (pay_last) begin
            phase_d = PH_SIZE;
            acc_d   = '0;
            pos_d   = '0;
            ext_d   = 1'b0;
            pend_d  = PCR_NONE;
          end
        end
        PH_TRAILER: begin
          if (eom) begin
            match_d = 2'd0;
            phase_d = PH_SIZE;
            acc_d   = '0;
            pos_d   = '0;
            ext_d   = 1'b0;
            pend_d  = PCR_NONE;
          end else if (trl_hit) begin
            match_d = match_q + 2'd1;
          end else begin
            match_d = entry_i.is_cr ? 2'd1 : 2'd0;
          end
        end
        PH_SIZE: begin
          if (size_err) begin
            phase_d = PH_ERROR;
          end else if (lf_ends) begin
            pend_d = PCR_NONE;
            if (acc_q == '0) begin
              phase_d = PH_TRAILER;
              match_d = 2'd2;
              rem_d   = '0;
            end else begin
              phase_d = PH_PAYLOAD;
              rem_d   = acc_q;
            end
          end else begin
            pend_d = PCR_NONE;
            if (pos_q < PosMax) begin
              pos_d = pos_q + 1'b1;
            end
            if (entry_i.is_cr) begin
              pend_d = counted ? PCR_COUNTED : PCR_UNCOUNTED;
            end else if (counted && entry_i.is_semi && !first) begin
              ext_d = 1'b1;
            end else if (counted) begin
              acc_d = {acc_q[LengthBits-5:0], entry_i.hex_val};
            end
          end
        end
        PH_ERROR: phase_d = PH_ERROR;
        default:  phase_d = PH_ERROR;
      endcase
    end
  end

  // Result of the current byte.
  always_comb begin
    res_valid = 1'b0;
    res_kind  = KIND_PAYLOAD;
    res_byte  = '0;
    res_last  = 1'b0;
    unique case (phase_q)
      PH_PAYLOAD: begin
        res_valid = 1'b1;
        res_byte  = entry_i.data;
        res_last  = pay_last;
      end
      PH_SKIP: res_valid = 1'b0;
      PH_TRAILER: begin
        if (eom) begin
          res_valid = 1'b1;
          res_kind  = KIND_EOM;
        end
      end
      PH_SIZE: begin
        if (size_err) begin
          res_valid = 1'b1;
          res_kind  = KIND_ERROR;
        end
      end
      PH_ERROR: begin
        res_valid = 1'b1;
        res_kind  = KIND_ERROR;
      end
      default: begin
        res_valid = 1'b1;
        res_kind  = KIND_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SIZE;
      rem_q       <= '0;
      acc_q       <= '0;
      pos_q       <= '0;
      ext_q       <= 1'b0;
      pend_q      <= PCR_NONE;
      match_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      acc_q   <= acc_d;
      pos_q   <= pos_d;
      ext_q   <= ext_d;
      pend_q  <= pend_d;
      match_q <= match_d;
      if (!out_valid_q || out_chan_o.ready) begin
        out_valid_q <= pop_o && res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_byte_q <= res_byte;
      out_kind_q <= res_kind;
      out_last_q <= res_last;
    end
  end

  assign out_chan_o.valid      = out_valid_q;
  assign out_chan_o.out_byte   = out_byte_q;
  assign out_chan_o.kind       = out_kind_q;
  assign out_chan_o.chunk_last = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ERROR |=> phase_q == PH_ERROR)
    else $error("error phase left");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> rem_q != '0)
    else $error("payload phase with nothing remaining");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= PosMax)
    else $error("line position past the counted characters");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && phase_q == PH_ERROR) |=> out_valid_q)
    else $error("byte in error phase gave no result");

endmodule
